### rtl/obm_pkg.sv
// ----------------------------------------------------------------------------
// obm_pkg
// Types and constants shared by the order matching book modules.
// ----------------------------------------------------------------------------
package obm_pkg;

  localparam int BOOK_DEPTH = 16;
  localparam int IDX_W      = $clog2(BOOK_DEPTH);
  localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_RESTING_FILLED  = 3'd0,
    KIND_INCOMING_FILLED = 3'd1,
    KIND_INCOMING_RESTED = 3'd2,
    KIND_BAD_SIDE        = 3'd3,
    KIND_BOOK_FULL       = 3'd4
  } kind_t;

  localparam logic [1:0] SIDE_BUY  = 2'd0;
  localparam logic [1:0] SIDE_SELL = 2'd1;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  trader;
    logic [7:0]  stock;
    logic [31:0] orig;
    logic [31:0] rem;
  } entry_t;

  typedef enum logic [1:0] {RD_SCAN, RD_SHIFT} rd_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_SHIFT, WR_APPEND, WR_OWN} wr_sel_t;
  typedef enum logic [1:0] {EMIT_NONE, EMIT_REST, EMIT_FINAL, EMIT_BAD} emit_sel_t;

  typedef struct packed {
    logic      ready;
    logic      load;
    logic      inc_idx;
    logic      set_sh;
    logic      inc_sh;
    logic      latch_ent;
    logic      dec_opp;
    rd_sel_t   rd_sel;
    wr_sel_t   wr_sel;
    emit_sel_t emit_sel;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_bad;
    logic rem_zero;
    logic scan_ok;
    logic match;
    logic ge;
    logic eval_more;
    logic sh_more;
    logic out_free;
  } sts_t;

endpackage

### rtl/obm_if.sv
// ----------------------------------------------------------------------------
// obm_order_if / obm_result_if
// Valid/ready channels for incoming orders and result records.
// ----------------------------------------------------------------------------
interface obm_order_if;
  logic        valid;
  logic        ready;
  logic [31:0] order_id;
  logic [1:0]  side;
  logic [7:0]  trader;
  logic [7:0]  stock;
  logic [31:0] quantity;

  modport source (output valid, order_id, side, trader, stock, quantity, input ready);
  modport sink   (input valid, order_id, side, trader, stock, quantity, output ready);
endinterface

interface obm_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] out_order_id;
  logic [7:0]  out_trader;
  logic [7:0]  out_stock;
  logic [31:0] original_qty;
  logic [31:0] remaining_qty;
  logic [31:0] counterpart_id;
  logic        last;

  modport source (output valid, kind, out_order_id, out_trader, out_stock, original_qty,
                  remaining_qty, counterpart_id, last, input ready);
  modport sink   (input valid, kind, out_order_id, out_trader, out_stock, original_qty,
                  remaining_qty, counterpart_id, last, output ready);
endinterface

### rtl/obm_ctrl.sv
// ----------------------------------------------------------------------------
// obm_ctrl
// Sequencer: scan, fill, book compaction, final record and bad-side record.
// ----------------------------------------------------------------------------
module obm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  obm_pkg::sts_t sts,
  output obm_pkg::cmd_t cmd
);
  import obm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_BAD, S_SCAN, S_LATCH, S_EVAL, S_SH_RD, S_SH_WR, S_SH_DONE, S_FINAL
  } state_t;

  state_t state, state_next;
  logic   partial, partial_next;

  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = RD_SCAN;
    cmd.wr_sel   = WR_NONE;
    cmd.emit_sel = EMIT_NONE;
    state_next   = state;
    partial_next = partial;
    unique case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.in_bad ? S_BAD : S_SCAN;
        end
      end
      S_BAD: begin
        if (sts.out_free) begin
          cmd.emit_sel = EMIT_BAD;
          state_next   = S_IDLE;
        end
      end
      S_SCAN: begin
        state_next = (!sts.rem_zero && sts.scan_ok) ? S_LATCH : S_FINAL;
      end
      S_LATCH: begin
        cmd.latch_ent = 1'b1;
        state_next    = S_EVAL;
      end
      S_EVAL: begin
        if (!sts.match) begin
          cmd.inc_idx = 1'b1;
          state_next  = S_SCAN;
        end else if (sts.out_free) begin
          cmd.emit_sel = EMIT_REST;
          cmd.set_sh   = 1'b1;
          partial_next = !sts.ge;
          state_next   = sts.eval_more ? S_SH_RD : S_SH_DONE;
        end
      end
      S_SH_RD: begin
        cmd.rd_sel = RD_SHIFT;
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.wr_sel = WR_SHIFT;
        cmd.inc_sh = 1'b1;
        state_next = sts.sh_more ? S_SH_RD : S_SH_DONE;
      end
      S_SH_DONE: begin
        if (partial) begin
          cmd.wr_sel = WR_APPEND;
          state_next = S_FINAL;
        end else begin
          cmd.dec_opp = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.emit_sel = EMIT_FINAL;
          cmd.wr_sel   = WR_OWN;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      partial <= 1'b0;
    end else begin
      state   <= state_next;
      partial <= partial_next;
    end
  end

endmodule

### rtl/obm_datapath.sv
// ----------------------------------------------------------------------------
// obm_datapath
// Book memories, counts, order and scan registers, result register.
// ----------------------------------------------------------------------------
module obm_datapath (
  input  logic          clk,
  input  logic          rst,
  input  obm_pkg::cmd_t cmd,
  output obm_pkg::sts_t sts,
  obm_order_if.sink     orders,
  obm_result_if.source  results
);
  import obm_pkg::*;

  entry_t buy_mem  [BOOK_DEPTH];
  entry_t sell_mem [BOOK_DEPTH];
  entry_t buy_rd, sell_rd, opp_rd;

  logic [CNT_W-1:0] buy_cnt, sell_cnt, opp_cnt, own_cnt;
  logic [CNT_W-1:0] idx, sh;
  logic [31:0]      ord_id, ord_qty, rem, last_cp;
  logic [7:0]       ord_trader, ord_stock;
  logic             ord_sell;
  entry_t           ent;

  logic [CNT_W:0]   idx_p1, sh_p1, sh_p2;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             wr_en, wr_buy, wr_sell, own_full, own_write;
  entry_t           wr_data;

  assign opp_cnt  = ord_sell ? buy_cnt : sell_cnt;
  assign own_cnt  = ord_sell ? sell_cnt : buy_cnt;
  assign opp_rd   = ord_sell ? buy_rd : sell_rd;
  assign own_full = (own_cnt >= CNT_W'(BOOK_DEPTH));
  assign idx_p1   = {1'b0, idx} + 1'b1;
  assign sh_p1    = {1'b0, sh} + 1'b1;
  assign sh_p2    = {1'b0, sh} + 2'd2;

  assign sts.in_valid  = orders.valid;
  assign sts.in_bad    = (orders.side != SIDE_BUY) && (orders.side != SIDE_SELL);
  assign sts.rem_zero  = (rem == '0);
  assign sts.scan_ok   = (idx < opp_cnt);
  assign sts.match     = (ent.stock == ord_stock);
  assign sts.ge        = (rem >= ent.rem);
  assign sts.eval_more = (idx_p1 < {1'b0, opp_cnt});
  assign sts.sh_more   = (sh_p2 < {1'b0, opp_cnt});
  assign sts.out_free  = !results.valid || results.ready;

  assign orders.ready = cmd.ready;

  assign own_write = !sts.rem_zero && !own_full;

  always_comb begin
    rd_addr = (cmd.rd_sel == RD_SHIFT) ? sh_p1[IDX_W-1:0] : idx[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = sh[IDX_W-1:0];
    wr_data = opp_rd;
    wr_buy  = 1'b0;
    wr_sell = 1'b0;
    case (cmd.wr_sel)
      WR_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = sh[IDX_W-1:0];
        wr_data = opp_rd;
      end
      WR_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(opp_cnt - 1'b1);
        wr_data = ent;
      end
      WR_OWN: begin
        wr_en   = own_write;
        wr_addr = own_cnt[IDX_W-1:0];
        wr_data = '{id: ord_id, trader: ord_trader, stock: ord_stock,
                    orig: ord_qty, rem: rem};
      end
      default: wr_en = 1'b0;
    endcase
    if (cmd.wr_sel == WR_OWN) begin
      wr_buy  = wr_en && !ord_sell;
      wr_sell = wr_en && ord_sell;
    end else begin
      wr_buy  = wr_en && ord_sell;
      wr_sell = wr_en && !ord_sell;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_buy) begin
      buy_mem[wr_addr] <= wr_data;
    end
    buy_rd <= buy_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_sell) begin
      sell_mem[wr_addr] <= wr_data;
    end
    sell_rd <= sell_mem[rd_addr];
  end

  // counts
  always_ff @(posedge clk) begin
    if (rst) begin
      buy_cnt  <= '0;
      sell_cnt <= '0;
    end else begin
      if (cmd.dec_opp) begin
        if (ord_sell) buy_cnt <= buy_cnt - 1'b1;
        else          sell_cnt <= sell_cnt - 1'b1;
      end
      if (cmd.wr_sel == WR_OWN && own_write) begin
        if (ord_sell) sell_cnt <= sell_cnt + 1'b1;
        else          buy_cnt <= buy_cnt + 1'b1;
      end
    end
  end

  // order and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ord_id     <= orders.order_id;
      ord_sell   <= (orders.side == SIDE_SELL);
      ord_trader <= orders.trader;
      ord_stock  <= orders.stock;
      ord_qty    <= orders.quantity;
      rem        <= orders.quantity;
      last_cp    <= '0;
      idx        <= '0;
    end
    if (cmd.inc_idx) idx <= idx + 1'b1;
    if (cmd.set_sh) sh <= idx;
    if (cmd.inc_sh) sh <= sh + 1'b1;
    if (cmd.latch_ent) ent <= opp_rd;
    if (cmd.emit_sel == EMIT_REST) begin
      last_cp <= ent.id;
      if (sts.ge) begin
        rem     <= rem - ent.rem;
        ent.rem <= '0;
      end else begin
        rem     <= '0;
        ent.rem <= ent.rem - rem;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.emit_sel != EMIT_NONE) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit_sel)
      EMIT_REST: begin
        results.kind           <= KIND_RESTING_FILLED;
        results.out_order_id   <= ent.id;
        results.out_trader     <= ent.trader;
        results.out_stock      <= ent.stock;
        results.original_qty   <= ent.orig;
        results.remaining_qty  <= sts.ge ? 32'd0 : (ent.rem - rem);
        results.counterpart_id <= ord_id;
        results.last           <= 1'b0;
      end
      EMIT_FINAL, EMIT_BAD: begin
        if (cmd.emit_sel == EMIT_BAD) results.kind <= KIND_BAD_SIDE;
        else if (sts.rem_zero)        results.kind <= KIND_INCOMING_FILLED;
        else if (!own_full)           results.kind <= KIND_INCOMING_RESTED;
        else                          results.kind <= KIND_BOOK_FULL;
        results.out_order_id   <= ord_id;
        results.out_trader     <= ord_trader;
        results.out_stock      <= ord_stock;
        results.original_qty   <= ord_qty;
        results.remaining_qty  <= rem;
        results.counterpart_id <= (cmd.emit_sel == EMIT_BAD) ? 32'd0 : last_cp;
        results.last           <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### rtl/order_matching_book.sv
// ----------------------------------------------------------------------------
// order_matching_book
// Two-sided order book matching from the head of the opposite side; a partly filled resting entry moves to its tail.
// Flow: accept the order, scan the opposite book, move entries down after each fill
// and close the fill, then emit the final record; a result not taken stalls it.
// Orders are handled one at a time: the next is accepted only after the last record.
// Reset: synchronous; both books empty, result channel idle.
// ----------------------------------------------------------------------------
module order_matching_book (
  input logic          clk,
  input logic          rst,
  obm_order_if.sink    orders,
  obm_result_if.source results
);
  import obm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  obm_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  obm_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .orders  (orders),
    .results (results)
  );

endmodule
